@@ sv/sndr_pkg.sv @@
package sndr_pkg;

   // feature count and fixed-point format
   localparam int NUM_INPUTS = 2;
   localparam int FRAC_BITS  = 12;
   localparam int ONE_Q      = 1 << FRAC_BITS;

   // data, multiplier operand and accumulator widths
   localparam int DATA_W = 16;
   localparam int OP_W   = DATA_W + 1;
   localparam int ACC_W  = 2 * OP_W;

   // sigmoid breakpoints and offsets, unsigned
   localparam int SIG_W = 20;
   localparam logic [SIG_W-1:0] SIG_ONE  = SIG_W'(ONE_Q);
   localparam logic [SIG_W-1:0] SIG_SAT  = SIG_W'(5 * ONE_Q);
   localparam logic [SIG_W-1:0] SIG_BRK2 = SIG_W'((19 * ONE_Q) >> 3);
   localparam logic [SIG_W-1:0] SIG_OFS2 = SIG_W'((27 * ONE_Q) >> 5);
   localparam logic [SIG_W-1:0] SIG_OFS1 = SIG_W'((5 * ONE_Q) >> 3);
   localparam logic [SIG_W-1:0] SIG_OFS0 = SIG_W'(ONE_Q >> 1);

   localparam logic signed [ACC_W-1:0] SAT_MAX = $signed(ACC_W'(32767));
   localparam logic signed [ACC_W-1:0] SAT_MIN = -$signed(ACC_W'(32768));

   // clamp a wide value to the 16-bit signed range
   function automatic logic signed [DATA_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > SAT_MAX) begin
         r = 16'sh7fff;
      end else if (v < SAT_MIN) begin
         r = 16'sh8000;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   // piecewise linear sigmoid, symmetric about one half
   function automatic logic signed [DATA_W-1:0] sigmoid(input logic signed [DATA_W-1:0] x);
      logic signed [DATA_W:0] xe;
      logic [DATA_W:0]        a;
      logic [SIG_W-1:0]       ae;
      logic [SIG_W-1:0]       y;
      xe = {x[DATA_W-1], x};
      a  = x[DATA_W-1] ? $unsigned(-xe) : $unsigned(xe);
      ae = SIG_W'(a);
      if (ae >= SIG_SAT) begin
         y = SIG_ONE;
      end else if (ae >= SIG_BRK2) begin
         y = (ae >> 5) + SIG_OFS2;
      end else if (ae >= SIG_ONE) begin
         y = (ae >> 3) + SIG_OFS1;
      end else begin
         y = (ae >> 2) + SIG_OFS0;
      end
      if (x[DATA_W-1]) begin
         y = SIG_ONE - y;
      end
      return DATA_W'(y);
   endfunction

endpackage

@@ sv/single_neuron_delta_rule_trainer.sv @@
// sequence: sum, activation, then on a train transaction derivative, rate, gain and
//   weight updates, before the result register; a new request is taken only in idle,
//   since the single shared multiplier is stepped through sum, derivative and updates
// reset (synchronous, active high): weights cleared, activation_mode = sigmoid,
//   learning_rate = 1.0, no result pending
module single_neuron_delta_rule_trainer
   import sndr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_action,
   input  logic signed [DATA_W-1:0] req_feature_a,
   input  logic signed [DATA_W-1:0] req_feature_b,
   input  logic signed [DATA_W-1:0] req_target_value,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_activation_out,
   output logic signed [DATA_W-1:0] rsp_weighted_sum,
   // register port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [2:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   // register map, index taken from byte address bit 2
   localparam logic CSR_MODE = 1'b0;
   localparam logic CSR_RATE = 1'b1;

   localparam int BIAS_IDX = NUM_INPUTS;
   localparam int IDX_B    = NUM_INPUTS - 1;

   localparam logic signed [DATA_W-1:0] ONE_D = DATA_W'(ONE_Q);
   localparam logic signed [OP_W-1:0]   ONE_O = OP_W'(ONE_Q);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM_A,
      ST_SUM_B,
      ST_SUM_C,
      ST_ACT,
      ST_DERIV,
      ST_RATE,
      ST_GAIN,
      ST_UPD_A,
      ST_UPD_B,
      ST_UPD_C,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic        mode_ff, mode_in;
   logic [14:0] rate_ff, rate_in;

   // transaction being worked on
   logic                     action_ff, action_in;
   logic signed [DATA_W-1:0] feat_a_ff, feat_a_in;
   logic signed [DATA_W-1:0] feat_b_ff, feat_b_in;
   logic signed [DATA_W-1:0] target_ff, target_in;

   // working values
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [DATA_W-1:0] sum_ff, sum_in;
   logic signed [DATA_W-1:0] act_ff, act_in;
   logic signed [DATA_W-1:0] deriv_ff, deriv_in;
   logic signed [DATA_W-1:0] gain_ff, gain_in;

   // weight store, last entry is the bias
   logic signed [DATA_W-1:0] w_ff [NUM_INPUTS+1];
   logic signed [DATA_W-1:0] w_in [NUM_INPUTS+1];

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_act_ff, rsp_act_in;
   logic signed [DATA_W-1:0] rsp_sum_ff, rsp_sum_in;

   // shared multiplier
   logic signed [OP_W-1:0]   mul_a;
   logic signed [OP_W-1:0]   mul_b;
   logic signed [ACC_W-1:0]  prod;
   logic signed [DATA_W-1:0] prod_sh;
   logic signed [DATA_W-1:0] err;
   logic signed [DATA_W-1:0] sum_now;

   logic csr_write;

   sndr_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // product back to Q format, floor rounding by arithmetic shift
   assign prod_sh = sat16(prod >>> FRAC_BITS);
   assign err     = sat16(ACC_W'(target_ff) - ACC_W'(act_ff));
   assign sum_now = sat16(acc_ff >>> FRAC_BITS);

   assign csr_write = psel & penable & pwrite & pready;
   assign pready    = 1'b1;

   // register readback
   always_comb begin
      unique case (paddr[2])
         CSR_MODE: prdata = {31'b0, mode_ff};
         CSR_RATE: prdata = {17'b0, rate_ff};
         default:  prdata = 32'b0;
      endcase
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_activation_out = rsp_act_ff;
   assign rsp_weighted_sum   = rsp_sum_ff;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      rate_in      = rate_ff;
      action_in    = action_ff;
      feat_a_in    = feat_a_ff;
      feat_b_in    = feat_b_ff;
      target_in    = target_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      act_in       = act_ff;
      deriv_in     = deriv_ff;
      gain_in      = gain_ff;
      w_in         = w_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_act_in   = rsp_act_ff;
      rsp_sum_in   = rsp_sum_ff;
      mul_a        = '0;
      mul_b        = '0;

      // response register drains independently of the sequencer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write) begin
         unique case (paddr[2])
            CSR_MODE: mode_in = pwdata[0];
            CSR_RATE: rate_in = pwdata[14:0];
            default:  ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               action_in = req_action;
               feat_a_in = req_feature_a;
               // single input design ignores the second feature
               feat_b_in = (NUM_INPUTS > 1) ? req_feature_b : '0;
               target_in = req_target_value;
               acc_in    = ACC_W'(w_ff[BIAS_IDX]) <<< FRAC_BITS;
               state_in  = ST_SUM_A;
            end
         end
         ST_SUM_A: begin
            mul_a    = OP_W'(feat_a_ff);
            mul_b    = OP_W'(w_ff[0]);
            state_in = ST_SUM_B;
         end
         ST_SUM_B: begin
            mul_a    = OP_W'(feat_b_ff);
            mul_b    = OP_W'(w_ff[IDX_B]);
            acc_in   = acc_ff + prod;
            state_in = ST_SUM_C;
         end
         ST_SUM_C: begin
            acc_in   = acc_ff + prod;
            state_in = ST_ACT;
         end
         ST_ACT: begin
            sum_in   = sum_now;
            act_in   = mode_ff ? sigmoid(sum_now) : sum_now;
            state_in = action_ff ? ST_DERIV : ST_DONE;
         end
         ST_DERIV: begin
            // sigmoid slope y * (1 - y)
            mul_a    = OP_W'(act_ff);
            mul_b    = ONE_O - OP_W'(act_ff);
            state_in = ST_RATE;
         end
         ST_RATE: begin
            deriv_in = mode_ff ? prod_sh : ONE_D;
            mul_a    = OP_W'({2'b0, rate_ff});
            mul_b    = OP_W'(err);
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            mul_a    = OP_W'(prod_sh);
            mul_b    = OP_W'(deriv_ff);
            state_in = ST_UPD_A;
         end
         ST_UPD_A: begin
            gain_in  = prod_sh;
            mul_a    = OP_W'(prod_sh);
            mul_b    = OP_W'(feat_a_ff);
            state_in = ST_UPD_B;
         end
         ST_UPD_B: begin
            w_in[0]        = sat16(ACC_W'(w_ff[0]) + ACC_W'(prod_sh));
            w_in[BIAS_IDX] = sat16(ACC_W'(w_ff[BIAS_IDX]) + ACC_W'(gain_ff));
            mul_a          = OP_W'(gain_ff);
            mul_b          = OP_W'(feat_b_ff);
            state_in       = ST_UPD_C;
         end
         ST_UPD_C: begin
            if (NUM_INPUTS > 1) begin
               w_in[IDX_B] = sat16(ACC_W'(w_ff[IDX_B]) + ACC_W'(prod_sh));
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait for room in the response register
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_act_in   = act_ff;
               rsp_sum_in   = sum_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 1'b1;
         rate_ff      <= 15'(ONE_Q);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i <= NUM_INPUTS; i++) begin
            w_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
         w_ff         <= w_in;
      end
      action_ff  <= action_in;
      feat_a_ff  <= feat_a_in;
      feat_b_ff  <= feat_b_in;
      target_ff  <= target_in;
      acc_ff     <= acc_in;
      sum_ff     <= sum_in;
      act_ff     <= act_in;
      deriv_ff   <= deriv_in;
      gain_ff    <= gain_in;
      rsp_act_ff <= rsp_act_in;
      rsp_sum_ff <= rsp_sum_in;
   end

endmodule

@@ sv/sndr_mul.sv @@
module sndr_mul
   import sndr_pkg::*;
(
   input  logic                    clock,
   input  logic signed [OP_W-1:0]  op_a,
   input  logic signed [OP_W-1:0]  op_b,
   output logic signed [ACC_W-1:0] prod
);

   logic signed [ACC_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] prod_in;

   // shared signed multiplier, product registered
   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ verif/tb_top.sv @@
module tb_top
   import sndr_pkg::*;
();

   // clocking and run bounds
   localparam int CLK_HALF      = 6;
   localparam int RUN_LIMIT     = 1000000;
   localparam int DRAIN_CYCLES  = 30;
   localparam int MAX_REPORTS   = 50;
   localparam int RANDOM_PHASES = 11;
   localparam int PHASE_ITEMS   = 150;

   // register map: index i at byte address 4*i
   localparam int REG_STRIDE     = 4;
   localparam int REG_ACT_MODE   = 0;
   localparam int REG_LEARN_RATE = 1;

   // field codes
   localparam logic MODE_LINEAR  = 1'b0;
   localparam logic MODE_SIGMOID = 1'b1;
   localparam logic ACT_INFER    = 1'b0;
   localparam logic ACT_TRAIN    = 1'b1;

   localparam logic [14:0] RATE_MAX = 15'h7fff;
   localparam logic [14:0] RATE_ONE = 15'(ONE_Q);

   typedef struct {
      logic                     action;
      logic signed [DATA_W-1:0] fa;
      logic signed [DATA_W-1:0] fb;
      logic signed [DATA_W-1:0] target;
   } neuron_req_type;

   typedef struct {
      logic signed [DATA_W-1:0] act;
      logic signed [DATA_W-1:0] sum;
   } neuron_rsp_type;

   // dut ports, inputs known from time zero
   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_stall;
   logic                     req_action       = ACT_INFER;
   logic signed [DATA_W-1:0] req_feature_a    = '0;
   logic signed [DATA_W-1:0] req_feature_b    = '0;
   logic signed [DATA_W-1:0] req_target_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall        = 1'b0;
   logic signed [DATA_W-1:0] rsp_activation_out;
   logic signed [DATA_W-1:0] rsp_weighted_sum;
   logic                     psel             = 1'b0;
   logic                     penable          = 1'b0;
   logic                     pwrite           = 1'b0;
   logic [2:0]               paddr            = '0;
   logic [31:0]              pwdata           = '0;
   logic [31:0]              prdata;
   logic                     pready;

   // shadow of the neuron: weights (bias last) and the two registers
   logic signed [DATA_W-1:0] w_store [NUM_INPUTS+1] = '{default: '0};
   logic                     act_mode_m = MODE_SIGMOID;
   logic [14:0]              rate_m     = RATE_ONE;

   neuron_req_type pending_reqs [$];       // filled by the stimulus, drained by the driver
   neuron_rsp_type expected_outcomes [$];  // predictions waiting for their transaction

   // bookkeeping
   int n_pushed    = 0;
   int n_loaded    = 0;
   int n_accepted  = 0;
   int n_trains    = 0;
   int n_results   = 0;
   int n_errors    = 0;
   int n_csr_wr    = 0;
   int n_cycles    = 0;

   // idle shaping state
   int             req_gap   = 0;
   bit             req_calm  = 1'b0;
   int             rsp_hold  = 0;
   bit             rsp_calm  = 1'b0;
   int             rsp_ticks = 0;
   neuron_req_type next_req;
   neuron_req_type seen_req;
   neuron_rsp_type got_pred;

   single_neuron_delta_rule_trainer i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_feature_a      (req_feature_a),
      .req_feature_b      (req_feature_b),
      .req_target_value   (req_target_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_activation_out (rsp_activation_out),
      .rsp_weighted_sum   (rsp_weighted_sum),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // ---------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------

   // clamp to the signed 16-bit range
   function automatic logic signed [DATA_W-1:0] clamp16(longint v);
      if (v > 32767) begin
         return 16'sh7fff;
      end
      if (v < -32768) begin
         return 16'sh8000;
      end
      return DATA_W'(v);
   endfunction

   // upper half of the piecewise sigmoid for a magnitude
   function automatic longint sig_half(longint mag);
      if (mag >= 5 * ONE_Q) begin
         return ONE_Q;
      end
      if (mag >= ((19 * ONE_Q) >>> 3)) begin
         return (mag >>> 5) + ((27 * ONE_Q) >>> 5);
      end
      if (mag >= ONE_Q) begin
         return (mag >>> 3) + ((5 * ONE_Q) >>> 3);
      end
      return (mag >>> 2) + (ONE_Q >>> 1);
   endfunction

   // one neuron step: outcome before the update, then the delta-rule update
   // on a train transaction; arithmetic shifts of longint round toward minus infinity
   function automatic neuron_rsp_type neuron_step(neuron_req_type r);
      longint                   feat [2];
      longint                   acc;
      longint                   sval;
      longint                   slope;
      logic signed [DATA_W-1:0] sum;
      logic signed [DATA_W-1:0] act;
      logic signed [DATA_W-1:0] err;
      logic signed [DATA_W-1:0] scaled;
      logic signed [DATA_W-1:0] grad;
      logic signed [DATA_W-1:0] delta;
      neuron_rsp_type           o;
      int                       i;
      feat[0] = longint'(r.fa);
      feat[1] = longint'(r.fb);
      // bias weight times 1.0 plus each feature times its weight
      acc = longint'(w_store[NUM_INPUTS]) * ONE_Q;
      for (i = 0; i < NUM_INPUTS; i++) begin
         acc += feat[i] * longint'(w_store[i]);
      end
      sum = clamp16(acc >>> FRAC_BITS);
      if (act_mode_m == MODE_LINEAR) begin
         act   = sum;
         slope = ONE_Q;
      end else begin
         if (sum >= 0) begin
            sval = sig_half(longint'(sum));
         end else begin
            sval = ONE_Q - sig_half(-longint'(sum));
         end
         act   = DATA_W'(sval);
         slope = (sval * (ONE_Q - sval)) >>> FRAC_BITS;
      end
      if (r.action == ACT_TRAIN) begin
         err    = clamp16(longint'(r.target) - longint'(act));
         scaled = clamp16((longint'(rate_m) * longint'(err)) >>> FRAC_BITS);
         grad   = clamp16((longint'(scaled) * slope) >>> FRAC_BITS);
         for (i = 0; i < NUM_INPUTS; i++) begin
            delta      = clamp16((longint'(grad) * feat[i]) >>> FRAC_BITS);
            w_store[i] = clamp16(longint'(w_store[i]) + longint'(delta));
         end
         w_store[NUM_INPUTS] = clamp16(longint'(w_store[NUM_INPUTS]) + longint'(grad));
      end
      o.act = act;
      o.sum = sum;
      return o;
   endfunction

   // ---------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------

   task automatic report_mismatch(string what, int got, int want);
      n_errors++;
      if (n_errors <= MAX_REPORTS) begin
         $display("tb_top: mismatch in %s after %0d results: got %0d, expected %0d",
                  what, n_results, got, want);
      end
   endtask

   // ---------------------------------------------------------------
   // idle shaping: mostly short gaps, a few long ones, none in calm stretches
   // ---------------------------------------------------------------

   function automatic int idle_len(bit calm);
      int r;
      if (calm) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 40);
   endfunction

   // ---------------------------------------------------------------
   // driver: request transactions change at the falling edge
   // ---------------------------------------------------------------

   always @(negedge clock) begin
      if (!reset) begin
         // an item is outstanding until the monitor has seen it accepted
         if (n_accepted == n_loaded) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               next_req = pending_reqs.pop_front();
               req_action       <= next_req.action;
               req_feature_a    <= next_req.fa;
               req_feature_b    <= next_req.fb;
               req_target_value <= next_req.target;
               req_valid        <= 1'b1;
               if (n_loaded % 64 == 0) begin
                  req_calm = ($urandom_range(0, 3) == 0);
               end
               n_loaded++;
               req_gap = idle_len(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_ticks++;
      if (rsp_ticks % 200 == 0) begin
         rsp_calm = ($urandom_range(0, 3) == 0);
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_hold = idle_len(rsp_calm);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: both handshakes sampled at the rising edge
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset) begin
         // result transaction against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_outcomes.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_weighted_sum, 0);
            end else begin
               got_pred = expected_outcomes.pop_front();
               if (rsp_activation_out !== got_pred.act) begin
                  report_mismatch("activation_out", rsp_activation_out, got_pred.act);
               end
               if (rsp_weighted_sum !== got_pred.sum) begin
                  report_mismatch("weighted_sum", rsp_weighted_sum, got_pred.sum);
               end
            end
            n_results++;
         end
         // request transaction: predict its outcome right away
         if (req_valid && !req_stall) begin
            seen_req.action = req_action;
            seen_req.fa     = req_feature_a;
            seen_req.fb     = req_feature_b;
            seen_req.target = req_target_value;
            expected_outcomes.push_back(neuron_step(seen_req));
            if (req_action == ACT_TRAIN) begin
               n_trains++;
            end
            n_accepted++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      n_cycles++;
      if (n_cycles > RUN_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // register access, setup then access phase
   // ---------------------------------------------------------------

   task automatic csr_write(int idx, logic [31:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 3'(REG_STRIDE * idx);
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      // shadow copy follows the write, masked to the register width
      if (idx == REG_ACT_MODE) begin
         act_mode_m = data[0];
      end else if (idx == REG_LEARN_RATE) begin
         rate_m = data[14:0];
      end
      n_csr_wr++;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_check(int idx);
      logic [31:0] want;
      want = (idx == REG_ACT_MODE) ? {31'b0, act_mode_m} : {17'b0, rate_m};
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= 3'(REG_STRIDE * idx);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         report_mismatch("register readback", prdata, want);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   task automatic queue_req(logic action, int fa, int fb, int target);
      neuron_req_type r;
      r.action = action;
      r.fa     = DATA_W'(fa);
      r.fb     = DATA_W'(fb);
      r.target = DATA_W'(target);
      pending_reqs.push_back(r);
      n_pushed++;
   endtask

   // wait until every queued transaction went in and its result came back;
   // the sender sits idle meanwhile
   task automatic settle();
      do @(negedge clock); while (n_accepted != n_pushed || expected_outcomes.size() != 0);
   endtask

   // mix of small values around the sigmoid knees, full range and corners
   function automatic int rand_value();
      int r;
      int corners [7];
      corners = '{-32768, -4096, -1, 0, 1, 4096, 32767};
      r = $urandom_range(0, 99);
      if (r < 45) begin
         return int'($urandom_range(0, 16383)) - 8192;
      end
      if (r < 75) begin
         return int'($signed(16'($urandom)));
      end
      return corners[$urandom_range(0, 6)];
   endfunction

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------

   initial begin
      int          probes [$];
      int          p;
      int          k;
      logic        mode_sel;
      logic [14:0] rate_sel;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values of both registers
      csr_check(REG_ACT_MODE);
      csr_check(REG_LEARN_RATE);

      // zero weights under the reset sigmoid: output sits at one half
      @(posedge clock);
      queue_req(ACT_INFER, 0, 0, 0);
      queue_req(ACT_INFER, 32767, -32768, -32768);
      settle();

      // linear, rate 1.0; upper data bits set to exercise masking.
      // these two trains leave feature_a weight at 1.0, the others at zero
      csr_write(REG_ACT_MODE, 32'hffff_fffe);
      csr_write(REG_LEARN_RATE, 32'hffff_9000);
      csr_check(REG_ACT_MODE);
      csr_check(REG_LEARN_RATE);
      @(posedge clock);
      queue_req(ACT_TRAIN, 4096, 0, 4096);
      queue_req(ACT_TRAIN, 0, 0, 0);
      queue_req(ACT_INFER, -100, 32767, 0);
      settle();

      // sigmoid with sum equal to feature_a: walk every knee from both sides
      csr_write(REG_ACT_MODE, 32'h8000_0003);
      csr_check(REG_ACT_MODE);
      probes = '{20480, 20479, 9728, 9727, 4096, 4095, 0, -1, -4095, -4096,
                 -9727, -9728, -20480, -20481, -32768};
      @(posedge clock);
      foreach (probes[i]) begin
         queue_req(ACT_INFER, probes[i], int'($urandom), int'($urandom));
      end
      queue_req(ACT_TRAIN, 8192, -4096, 0);
      settle();

      // linear at the largest rate: saturation everywhere in the update chain
      csr_write(REG_ACT_MODE, {31'b0, MODE_LINEAR});
      csr_write(REG_LEARN_RATE, {17'b0, RATE_MAX});
      @(posedge clock);
      queue_req(ACT_TRAIN, 32767, 32767, 32767);
      queue_req(ACT_TRAIN, -32768, -32768, -32768);
      queue_req(ACT_TRAIN, 32767, -32768, 0);
      settle();

      // zero rate: training must leave the weights alone
      csr_write(REG_LEARN_RATE, 32'h0000_8000);
      @(posedge clock);
      queue_req(ACT_TRAIN, 1000, -1000, 5000);
      queue_req(ACT_INFER, 1000, -1000, 0);
      settle();

      // random phases, each under its own register setting
      for (p = 0; p < RANDOM_PHASES; p++) begin
         mode_sel = (p % 2 == 0) ? MODE_SIGMOID : MODE_LINEAR;
         case (p % 5)
            0: begin
               rate_sel = RATE_MAX;
            end
            1: begin
               rate_sel = '0;
            end
            2: begin
               rate_sel = RATE_ONE;
            end
            3: begin
               rate_sel = 15'($urandom_range(1, 512));
            end
            default: begin
               rate_sel = 15'($urandom);
            end
         endcase
         csr_write(REG_ACT_MODE, ($urandom & 32'hffff_fffe) | {31'b0, mode_sel});
         csr_write(REG_LEARN_RATE, ($urandom & 32'hffff_8000) | {17'b0, rate_sel});
         csr_check(REG_ACT_MODE);
         csr_check(REG_LEARN_RATE);
         @(posedge clock);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            queue_req(($urandom_range(0, 99) < 60) ? ACT_TRAIN : ACT_INFER,
                      rand_value(), rand_value(), rand_value());
         end
         settle();
      end

      // drain: anything arriving now is unexpected
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb_top: %0d transactions (%0d train), %0d results compared",
               n_accepted, n_trains, n_results);
      $display("tb_top: %0d register writes over linear and sigmoid, rates 0 to 32767",
               n_csr_wr);
      if (n_errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
